// ===== rtl/two_pkg.sv =====
// Package for the tracking-wheel odometry block: shared types, codes and constants.
// Depends on nothing; used by two_ctrl, two_datapath and tracking_wheel_odometry_core.

package two_pkg;

	// Default number of CORDIC rotations (legal range 8 to 24).
	localparam int CORDIC_STEPS_DEF = 16;

	// Width of the step counter shared by the angle conversion, CORDIC and multiply phases.
	localparam int STEP_W = 5;

	// Cycles of the binary-angle conversion.
	localparam int DIV_CYCLES = 2;

	// Width of the configuration register index.
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HORIZ = 1'b0,
		CFG_VERT  = 1'b1
	} cfg_idx_t;

	// Input item commands.
	typedef enum logic {
		CMD_UPDATE   = 1'b0,
		CMD_SET_POSE = 1'b1
	} cmd_t;

	// Phases of the shared multiplier sequence.
	typedef enum logic [2:0] {
		MP_SCALE_V = 3'd0,
		MP_SCALE_H = 3'd1,
		MP_DX_COS  = 3'd2,
		MP_DY_SIN  = 3'd3,
		MP_DX_SIN  = 3'd4,
		MP_DY_COS  = 3'd5,
		MP_FINISH  = 3'd6
	} mul_phase_t;

	// Reset value of both inches-per-tick factors.
	localparam logic [31:0] FACTOR_RESET = 32'd1030700;

	// Angle reduction in centidegrees: (90000 - heading) mod 36000.
	localparam logic [16:0] ANG_OFFSET = 17'd90000;
	localparam logic [16:0] ANG_FULL   = 17'd36000;
	localparam logic [16:0] ANG_TWO    = 17'd72000;

	// Binary angle round((a * 2^32) / 36000), split as a * floor(2^32 / 36000) plus
	// floor((a * 728 + 562) / 1125), where 728 is (2^32 mod 36000) / 32 and 562 is half
	// of the divisor over 32. The last quotient uses a reciprocal of 1125 that is exact
	// for every numerator below 2^25.
	localparam logic [16:0] BAM_WHOLE     = 17'd119304;
	localparam logic [9:0]  BAM_FRAC_MUL  = 10'd728;
	localparam logic [9:0]  BAM_FRAC_BIAS = 10'd562;
	localparam logic [25:0] BAM_RECIP     = 26'd61083980;
	localparam int          BAM_RECIP_SH  = 36;

	// CORDIC constants in Q1.30 and binary-angle units.
	localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
	localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              load;
		logic              div_step;
		logic              rot_init;
		logic              rot_step;
		logic              mul_en;
		logic              commit;
		logic [STEP_W-1:0] step;
	} ctrl_cmd_t;

	// Arctangent of 2^-i in binary-angle units.
	function automatic logic [29:0] atan_lookup(input logic [STEP_W-1:0] idx);
		logic [29:0] val;
		case (idx)
			5'd0:    val = 30'd536870912;
			5'd1:    val = 30'd316933406;
			5'd2:    val = 30'd167458907;
			5'd3:    val = 30'd85004756;
			5'd4:    val = 30'd42667331;
			5'd5:    val = 30'd21354465;
			5'd6:    val = 30'd10679838;
			5'd7:    val = 30'd5340245;
			5'd8:    val = 30'd2670163;
			5'd9:    val = 30'd1335087;
			5'd10:   val = 30'd667544;
			5'd11:   val = 30'd333772;
			5'd12:   val = 30'd166886;
			5'd13:   val = 30'd83443;
			5'd14:   val = 30'd41722;
			5'd15:   val = 30'd20861;
			5'd16:   val = 30'd10430;
			5'd17:   val = 30'd5215;
			5'd18:   val = 30'd2608;
			5'd19:   val = 30'd1304;
			5'd20:   val = 30'd652;
			5'd21:   val = 30'd326;
			5'd22:   val = 30'd163;
			5'd23:   val = 30'd81;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

// ===== rtl/two_ctrl.sv =====
// Controller of the odometry block: sequences angle conversion, CORDIC, multiplier and commit.
// Depends on two_pkg; drives two_datapath through a ctrl_cmd_t command bundle.

module two_ctrl #(
	parameter int CORDIC_STEPS = two_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output two_pkg::ctrl_cmd_t  ctl
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_PREP  = 6'b000100,
		ST_ROT   = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_WRITE = 6'b100000
	} state_t;

	localparam logic [two_pkg::STEP_W-1:0] DIV_LAST = two_pkg::STEP_W'(two_pkg::DIV_CYCLES - 1);
	localparam logic [two_pkg::STEP_W-1:0] ROT_LAST = two_pkg::STEP_W'(CORDIC_STEPS - 1);

	state_t                      state_q, state_nxt;
	logic [two_pkg::STEP_W-1:0]  cnt_q, cnt_nxt;
	logic                        out_valid_q;
	logic                        accept;
	logic                        commit;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign commit    = (state_q == ST_WRITE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// Next state and step counter.
	always_comb begin
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				cnt_nxt = '0;
				if (accept) begin
					if (two_pkg::cmd_t'(cmd) == two_pkg::CMD_SET_POSE) begin
						state_nxt = ST_WRITE;
					end else begin
						state_nxt = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cnt_nxt = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					cnt_nxt   = '0;
					state_nxt = ST_PREP;
				end
			end
			ST_PREP: begin
				cnt_nxt   = '0;
				state_nxt = ST_ROT;
			end
			ST_ROT: begin
				cnt_nxt = cnt_q + 1'b1;
				if (cnt_q == ROT_LAST) begin
					cnt_nxt   = '0;
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cnt_nxt = cnt_q + 1'b1;
				if (two_pkg::mul_phase_t'(cnt_q[2:0]) == two_pkg::MP_FINISH) begin
					cnt_nxt   = '0;
					state_nxt = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (commit) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
				cnt_nxt   = '0;
			end
		endcase
	end

	// State, counter and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Commands to the datapath.
	always_comb begin
		ctl          = '0;
		ctl.load     = accept;
		ctl.div_step = (state_q == ST_DIV);
		ctl.rot_init = (state_q == ST_PREP);
		ctl.rot_step = (state_q == ST_ROT);
		ctl.mul_en   = (state_q == ST_MUL);
		ctl.commit   = commit;
		ctl.step     = cnt_q;
	end

endmodule

// ===== rtl/two_datapath.sv =====
// Datapath of the odometry block: deltas, binary-angle conversion, CORDIC, shared multiplier
// and the saturating position accumulators. Depends on two_pkg; commanded by two_ctrl.

module two_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  two_pkg::ctrl_cmd_t                  ctl,
	input  logic                                cmd,
	input  logic signed [31:0]                  horiz_ticks,
	input  logic signed [31:0]                  vert_ticks,
	input  logic [15:0]                         imu_heading_cdeg,
	input  logic signed [31:0]                  start_x,
	input  logic signed [31:0]                  start_y,
	input  logic                                cfg_we,
	input  logic [two_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                         cfg_data,
	output logic signed [31:0]                  pos_x,
	output logic signed [31:0]                  pos_y
);

	localparam logic signed [67:0] SAT_HI  = 68'sd2147483647;
	localparam logic signed [67:0] SAT_LO  = -68'sd2147483648;
	localparam logic signed [67:0] RND_16  = 68'sd32768;
	localparam logic signed [67:0] RND_30  = 68'sd536870912;

	// Clamp a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Configuration and architectural state.
	logic [31:0]          fh_q, fv_q;
	logic [31:0]          prev_h_q, prev_v_q;
	logic signed [31:0]   acc_x_q, acc_y_q;

	// Per-item working registers.
	logic                 cmd_q;
	logic signed [31:0]   dh_q, dv_q;
	logic signed [31:0]   start_x_q, start_y_q;
	logic [15:0]          ang_q;
	logic [31:0]          whole_q;
	logic [24:0]          frac_q;
	logic [31:0]          quo_q;
	logic signed [33:0]   cx_q, cy_q, cz_q;
	logic                 flip_q;
	logic signed [67:0]   prod_q;
	logic signed [31:0]   dx_q, dy_q;
	logic signed [67:0]   sx_q, sy_q;

	// Combinational helpers.
	logic [16:0]          hd_off, hd_red;
	logic [31:0]          whole_num;
	logic [24:0]          frac_num;
	logic [50:0]          frac_prod;
	logic signed [33:0]   z_init;
	logic signed [33:0]   sh_x, sh_y, at_step;
	logic signed [33:0]   cos_v, sin_v;
	logic signed [33:0]   op_a, op_b;
	logic signed [31:0]   scaled;
	logic signed [31:0]   new_x, new_y;
	two_pkg::mul_phase_t  phase;

	// Heading to angle in centidegrees, reduced below a full turn.
	assign hd_off = two_pkg::ANG_OFFSET - {1'b0, imu_heading_cdeg};
	always_comb begin
		if (hd_off >= two_pkg::ANG_TWO) begin
			hd_red = hd_off - two_pkg::ANG_TWO;
		end else if (hd_off >= two_pkg::ANG_FULL) begin
			hd_red = hd_off - two_pkg::ANG_FULL;
		end else begin
			hd_red = hd_off;
		end
	end

	// Binary-angle conversion: whole part and fraction numerator, then a reciprocal quotient.
	assign whole_num = 32'(ang_q) * 32'(two_pkg::BAM_WHOLE);
	assign frac_num  = 25'(ang_q) * 25'(two_pkg::BAM_FRAC_MUL) + 25'(two_pkg::BAM_FRAC_BIAS);
	assign frac_prod = 51'(frac_q) * 51'(two_pkg::BAM_RECIP);

	// Binary angle read as a signed angle, for the fold into the right half plane.
	assign z_init = 34'($signed(quo_q));

	// CORDIC shifts and angle step.
	assign sh_x    = cx_q >>> ctl.step;
	assign sh_y    = cy_q >>> ctl.step;
	assign at_step = $signed({4'b0000, two_pkg::atan_lookup(ctl.step)});

	// Cosine and sine with the half-turn fold undone.
	assign cos_v = flip_q ? -cx_q : cx_q;
	assign sin_v = flip_q ? -cy_q : cy_q;

	// Operand selection of the shared multiplier.
	assign phase = two_pkg::mul_phase_t'(ctl.step[2:0]);
	always_comb begin
		case (phase)
			two_pkg::MP_SCALE_V: begin
				op_a = 34'(dv_q);
				op_b = $signed({2'b00, fv_q});
			end
			two_pkg::MP_SCALE_H: begin
				op_a = 34'(dh_q);
				op_b = $signed({2'b00, fh_q});
			end
			two_pkg::MP_DX_COS: begin
				op_a = 34'(dx_q);
				op_b = cos_v;
			end
			two_pkg::MP_DY_SIN: begin
				op_a = 34'(dy_q);
				op_b = sin_v;
			end
			two_pkg::MP_DX_SIN: begin
				op_a = 34'(dx_q);
				op_b = sin_v;
			end
			two_pkg::MP_DY_COS: begin
				op_a = 34'(dy_q);
				op_b = cos_v;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Scaled delta: Q36.32 product rounded half up to Q16.16 and clamped.
	assign scaled = sat32((prod_q + RND_16) >>> 16);

	// New position: rotated sums rounded from Q.46 to Q16.16, accumulated and clamped.
	assign new_x = sat32(((sx_q + RND_30) >>> 30) + 68'(acc_x_q));
	assign new_y = sat32(((sy_q + RND_30) >>> 30) + 68'(acc_y_q));

	// Registers that reset: factors, previous counts and the position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q     <= two_pkg::FACTOR_RESET;
			fv_q     <= two_pkg::FACTOR_RESET;
			prev_h_q <= '0;
			prev_v_q <= '0;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (two_pkg::cfg_idx_t'(cfg_index))
					two_pkg::CFG_HORIZ: fh_q <= cfg_data;
					two_pkg::CFG_VERT:  fv_q <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.load && (two_pkg::cmd_t'(cmd) == two_pkg::CMD_UPDATE)) begin
				prev_h_q <= horiz_ticks;
				prev_v_q <= vert_ticks;
			end
			if (ctl.commit) begin
				if (two_pkg::cmd_t'(cmd_q) == two_pkg::CMD_SET_POSE) begin
					acc_x_q <= start_x_q;
					acc_y_q <= start_y_q;
				end else begin
					acc_x_q <= new_x;
					acc_y_q <= new_y;
				end
			end
		end
	end

	// Working registers of one transaction.
	always_ff @(posedge clk) begin
		// Capture the item and take the wrapping deltas.
		if (ctl.load) begin
			cmd_q     <= cmd;
			dh_q      <= $signed(horiz_ticks - prev_h_q);
			dv_q      <= $signed(vert_ticks - prev_v_q);
			start_x_q <= start_x;
			start_y_q <= start_y;
			ang_q     <= hd_red[15:0];
		end

		// Angle to binary angle: partial terms first, then the reciprocal quotient.
		if (ctl.div_step) begin
			if (ctl.step == '0) begin
				whole_q <= whole_num;
				frac_q  <= frac_num;
			end else begin
				quo_q <= whole_q + 32'(frac_prod >> two_pkg::BAM_RECIP_SH);
			end
		end

		// CORDIC start vector and folded angle.
		if (ctl.rot_init) begin
			cx_q <= two_pkg::CORDIC_GAIN;
			cy_q <= '0;
			if (z_init > two_pkg::QUARTER_TURN) begin
				cz_q   <= z_init - two_pkg::HALF_TURN;
				flip_q <= 1'b1;
			end else if (z_init < -two_pkg::QUARTER_TURN) begin
				cz_q   <= z_init + two_pkg::HALF_TURN;
				flip_q <= 1'b1;
			end else begin
				cz_q   <= z_init;
				flip_q <= 1'b0;
			end
		end

		// One CORDIC rotation.
		if (ctl.rot_step) begin
			if (!cz_q[33]) begin
				cx_q <= cx_q - sh_y;
				cy_q <= cy_q + sh_x;
				cz_q <= cz_q - at_step;
			end else begin
				cx_q <= cx_q + sh_y;
				cy_q <= cy_q - sh_x;
				cz_q <= cz_q + at_step;
			end
		end

		// Shared multiplier; each phase after the first also retires the previous product.
		if (ctl.mul_en) begin
			prod_q <= op_a * op_b;
			case (phase)
				two_pkg::MP_SCALE_H: dx_q <= scaled;
				two_pkg::MP_DX_COS:  dy_q <= scaled;
				two_pkg::MP_DY_SIN:  sx_q <= prod_q;
				two_pkg::MP_DX_SIN:  sx_q <= sx_q + prod_q;
				two_pkg::MP_DY_COS:  sy_q <= prod_q;
				two_pkg::MP_FINISH:  sy_q <= sy_q - prod_q;
				default: ;
			endcase
		end
	end

	// The position registers hold the result until the next commit.
	assign pos_x = acc_x_q;
	assign pos_y = acc_y_q;

endmodule

// ===== rtl/tracking_wheel_odometry_core.sv =====
// Top level of the tracking-wheel odometry block: controller plus datapath.
// Depends on two_pkg, two_ctrl and two_datapath.
//
//   Channel  Handshake            Payload
//   -------  -------------------  ------------------------------------------------
//   input    in_valid / in_ready  cmd, horiz_ticks, vert_ticks, imu_heading_cdeg,
//                                 start_x, start_y
//   output   out_valid/out_ready  pos_x, pos_y
//   config   cfg_we               cfg_index, cfg_data
//
// An update runs from acceptance through the binary-angle conversion, the CORDIC
// load, CORDIC_STEPS rotations, the shared-multiplier phases and the commit, and
// returns to idle before the next item is accepted. A set-pose item goes straight
// to the commit. Reset clears the position and the previous encoder counts and
// loads both factors. A new item is accepted while the previous result waits; the
// commit of its result waits until the output has been taken.

module tracking_wheel_odometry_core #(
	parameter int CORDIC_STEPS = two_pkg::CORDIC_STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic signed [31:0]             horiz_ticks,
	input  logic signed [31:0]             vert_ticks,
	input  logic [15:0]                    imu_heading_cdeg,
	input  logic signed [31:0]             start_x,
	input  logic signed [31:0]             start_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [31:0]             pos_x,
	output logic signed [31:0]             pos_y,
	input  logic                           cfg_we,
	input  logic [two_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);

	two_pkg::ctrl_cmd_t ctl;

	// Sequencer.
	two_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// Arithmetic and state.
	two_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.cmd              (cmd),
		.horiz_ticks      (horiz_ticks),
		.vert_ticks       (vert_ticks),
		.imu_heading_cdeg (imu_heading_cdeg),
		.start_x          (start_x),
		.start_y          (start_y),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.pos_x            (pos_x),
		.pos_y            (pos_y)
	);

endmodule
